// ===== hdl/gu2x_pkg.sv =====
`timescale 1ns / 1ps

package gu2x_pkg;

   localparam int MAX_COLS_DEF    = 1024;
   localparam int SAMPLE_BITS_DEF = 32;
   localparam int QUEUE_DEPTH     = 4;

   localparam int ROW_W      = 17;
   localparam int COL_W      = 11;
   localparam int COLS_REG_W = 11;
   localparam int ROWS_REG_W = 16;
   localparam int ROW_IDX_W  = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_ADDR_W = 1;
   localparam int KIND_W     = 9;

   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_COLS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_ROWS = 1'b1;

   localparam logic [COLS_REG_W-1:0] GRID_COLS_RST = 11'd180;
   localparam logic [ROWS_REG_W-1:0] GRID_ROWS_RST = 16'd280;

   // result kinds, one bit each, in emission order
   localparam logic [KIND_W-1:0] KIND_UP_DIAG   = 9'b000000001;
   localparam logic [KIND_W-1:0] KIND_UP_VERT   = 9'b000000010;
   localparam logic [KIND_W-1:0] KIND_UP_EDGE   = 9'b000000100;
   localparam logic [KIND_W-1:0] KIND_MID_HORZ  = 9'b000001000;
   localparam logic [KIND_W-1:0] KIND_MID_SELF  = 9'b000010000;
   localparam logic [KIND_W-1:0] KIND_MID_EDGE  = 9'b000100000;
   localparam logic [KIND_W-1:0] KIND_BOT_HORZ  = 9'b001000000;
   localparam logic [KIND_W-1:0] KIND_BOT_SELF  = 9'b010000000;
   localparam logic [KIND_W-1:0] KIND_BOT_EDGE  = 9'b100000000;

   typedef struct packed {
      logic [KIND_W-1:0] kinds;
      logic [ROW_W-1:0]  row_up;
      logic [ROW_W-1:0]  row_mid;
      logic [ROW_W-1:0]  row_bot;
      logic [COL_W-1:0]  col_left;
      logic [COL_W-1:0]  col_self;
      logic [COL_W-1:0]  col_edge;
   } gu2x_ctrl_type;

endpackage

// ===== hdl/grid_upsample_2x_bilinear_core.sv =====
`timescale 1ns / 1ps

// channel  | dir | handshake              | payload
// req      | in  | req_tvalid/req_tready  | tdata: sample
// rsp      | out | rsp_tvalid/rsp_tready  | tdata: out_row, out_col, value; tlast: last
// csr      | in  | csr_wen                | csr_addr, csr_wdata
//
// one input word gives 1 to 9 output words, 4 on average; the output port moves
// one word per cycle while rsp_tready is high. a word is pushed into the queue
// in the cycle after it is taken and then passes the queue, the current-word and
// output registers. reset clears counters, queue and config (180 cols, 280 rows);
// the line buffer is not cleared. rsp_tready low fills the 4-entry queue, and
// req_tready falls once the queue and the word in flight would fill it

module grid_upsample_2x_bilinear_core #(
   parameter int MAX_COLS    = gu2x_pkg::MAX_COLS_DEF,
   parameter int SAMPLE_BITS = gu2x_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sample
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_row, out_col, value
   output logic [((SAMPLE_BITS+35)/8)*8-1:0]   rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_wen,
   input  logic [gu2x_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [gu2x_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SB     = SAMPLE_BITS;
   localparam int QDEPTH = gu2x_pkg::QUEUE_DEPTH;
   localparam int QCW    = $clog2(QDEPTH + 1);
   localparam int CTRL_W = $bits(gu2x_pkg::gu2x_ctrl_type);
   localparam int Q_W    = CTRL_W + 4 * SB;
   localparam int RSP_W  = ((SB + 35) / 8) * 8;

   logic [gu2x_pkg::COLS_REG_W-1:0] grid_cols_ff;
   logic [gu2x_pkg::ROWS_REG_W-1:0] grid_rows_ff;

   logic                     push, pop, head_valid;
   gu2x_pkg::gu2x_ctrl_type  push_ctrl, head_ctrl;
   logic [4*SB-1:0]          push_values, head_values;
   logic [Q_W-1:0]           head_data;
   logic [QCW-1:0]           q_count;
   logic [gu2x_pkg::ROW_W-1:0] out_row;
   logic [gu2x_pkg::COL_W-1:0] out_col;
   logic [SB-1:0]            value;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= gu2x_pkg::GRID_COLS_RST;
         grid_rows_ff <= gu2x_pkg::GRID_ROWS_RST;
      end else if (csr_wen) begin
         case (csr_addr)
            gu2x_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_wdata[gu2x_pkg::COLS_REG_W-1:0];
            gu2x_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_wdata[gu2x_pkg::ROWS_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   gu2x_front #(
      .MAX_COLS    (MAX_COLS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .QDEPTH      (QDEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .grid_cols   (grid_cols_ff),
      .grid_rows   (grid_rows_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .sample      (req_tdata[SB-1:0]),
      .q_count     (q_count),
      .push        (push),
      .push_ctrl   (push_ctrl),
      .push_values (push_values)
   );

   gu2x_queue #(
      .DATA_W (Q_W),
      .DEPTH  (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_ctrl, push_values}),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .count      (q_count)
   );

   assign head_ctrl   = head_data[Q_W-1:4*SB];
   assign head_values = head_data[4*SB-1:0];

   gu2x_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_ctrl   (head_ctrl),
      .head_values (head_values),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .out_row     (out_row),
      .out_col     (out_col),
      .value       (value),
      .last        (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({value, out_col, out_row});

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (32'(q_count) < QDEPTH || pop))
      else $error("queue overflow");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && q_count == '0))
      else $error("output or queue busy after reset");

endmodule

// ===== hdl/gu2x_front.sv =====
`timescale 1ns / 1ps

module gu2x_front #(
   parameter int MAX_COLS    = gu2x_pkg::MAX_COLS_DEF,
   parameter int SAMPLE_BITS = gu2x_pkg::SAMPLE_BITS_DEF,
   parameter int QDEPTH      = gu2x_pkg::QUEUE_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [gu2x_pkg::COLS_REG_W-1:0]        grid_cols,
   input  logic [gu2x_pkg::ROWS_REG_W-1:0]        grid_rows,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [SAMPLE_BITS-1:0]                 sample,
   input  logic [$clog2(QDEPTH+1)-1:0]            q_count,
   output logic                                   push,
   output gu2x_pkg::gu2x_ctrl_type                push_ctrl,
   output logic [4*SAMPLE_BITS-1:0]               push_values
);

   localparam int CW    = $clog2(MAX_COLS);
   localparam int CNT_W = $clog2(MAX_COLS + 1);
   localparam int QCW   = $clog2(QDEPTH + 1);
   localparam int COL_W = gu2x_pkg::COL_W;
   localparam int ROW_W = gu2x_pkg::ROW_W;
   localparam int RW    = gu2x_pkg::ROW_IDX_W;
   localparam int SB    = SAMPLE_BITS;

   logic [CW-1:0]            col_ff, col_in;
   logic [RW-1:0]            row_ff, row_in;
   logic                     a_valid_ff;
   logic                     a_rnz_ff;
   logic [SB-1:0]            a_s_ff;
   gu2x_pkg::gu2x_ctrl_type  a_ctrl_ff, a_ctrl_in;
   logic [SB-1:0]            rd_ff;
   logic [SB-1:0]            left_ff;
   logic [SB-1:0]            ul_ff;
   logic [SB-1:0]            row_mem [MAX_COLS];

   logic [CNT_W-1:0]         cols_eff;
   logic [RW-1:0]            rows_eff;
   logic [CW-1:0]            c;
   logic                     last_col, last_row, rnz, cnz, accept;
   logic [CW:0]              col_self_full, col_left_full;
   logic [CNT_W:0]           col_edge_full;
   logic [SB-1:0]            above;
   logic [SB+1:0]            sum_v, sum_h, sum_q;

   always_comb begin
      if (grid_cols == '0) begin
         cols_eff = CNT_W'(1);
      end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
         cols_eff = CNT_W'(MAX_COLS);
      end else begin
         cols_eff = CNT_W'(grid_cols);
      end
      rows_eff = (grid_rows == '0) ? RW'(1) : grid_rows;
      if (CNT_W'(col_ff) >= cols_eff) begin
         c = CW'(cols_eff - CNT_W'(1));
      end else begin
         c = col_ff;
      end
      last_col = (CNT_W'(c) == cols_eff - CNT_W'(1));
      last_row = (row_ff >= rows_eff - RW'(1));
      rnz = (row_ff != '0);
      cnz = (c != '0);
      accept = req_tvalid && req_tready;

      col_self_full = {c, 1'b0};
      col_left_full = col_self_full - (CW+1)'(1);
      col_edge_full = {cols_eff, 1'b0} - (CNT_W+1)'(1);

      a_ctrl_in.row_mid  = {row_ff, 1'b0};
      a_ctrl_in.row_up   = {row_ff, 1'b0} - ROW_W'(1);
      a_ctrl_in.row_bot  = {rows_eff, 1'b0} - ROW_W'(1);
      a_ctrl_in.col_self = COL_W'(col_self_full);
      a_ctrl_in.col_left = COL_W'(col_left_full);
      a_ctrl_in.col_edge = COL_W'(col_edge_full);
      a_ctrl_in.kinds = gu2x_pkg::KIND_MID_SELF;
      if (rnz && cnz) a_ctrl_in.kinds = a_ctrl_in.kinds | gu2x_pkg::KIND_UP_DIAG;
      if (rnz) a_ctrl_in.kinds = a_ctrl_in.kinds | gu2x_pkg::KIND_UP_VERT;
      if (rnz && last_col) a_ctrl_in.kinds = a_ctrl_in.kinds | gu2x_pkg::KIND_UP_EDGE;
      if (cnz) a_ctrl_in.kinds = a_ctrl_in.kinds | gu2x_pkg::KIND_MID_HORZ;
      if (last_col) a_ctrl_in.kinds = a_ctrl_in.kinds | gu2x_pkg::KIND_MID_EDGE;
      if (last_row && cnz) a_ctrl_in.kinds = a_ctrl_in.kinds | gu2x_pkg::KIND_BOT_HORZ;
      if (last_row) a_ctrl_in.kinds = a_ctrl_in.kinds | gu2x_pkg::KIND_BOT_SELF;
      if (last_row && last_col) a_ctrl_in.kinds = a_ctrl_in.kinds | gu2x_pkg::KIND_BOT_EDGE;

      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + RW'(1);
      end else begin
         col_in = c + CW'(1);
         row_in = row_ff;
      end
   end

   // room for the word in flight plus this one
   assign req_tready = ((QCW+1)'(q_count) + (QCW+1)'(a_valid_ff)) < (QCW+1)'(QDEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
         left_ff    <= '0;
         ul_ff      <= '0;
      end else begin
         a_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (a_valid_ff) begin
            left_ff <= a_s_ff;
            ul_ff   <= above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_s_ff    <= sample;
         a_rnz_ff  <= rnz;
         a_ctrl_ff <= a_ctrl_in;
      end
   end

   // line buffer, read before write at the same address
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff      <= row_mem[c];
         row_mem[c] <= sample;
      end
   end

   always_comb begin
      above = a_rnz_ff ? rd_ff : '0;
      sum_v = {{2{above[SB-1]}}, above} + {{2{a_s_ff[SB-1]}}, a_s_ff};
      sum_h = {{2{left_ff[SB-1]}}, left_ff} + {{2{a_s_ff[SB-1]}}, a_s_ff};
      sum_q = sum_v + {{2{left_ff[SB-1]}}, left_ff} + {{2{ul_ff[SB-1]}}, ul_ff};
   end

   assign push        = a_valid_ff;
   assign push_ctrl   = a_ctrl_ff;
   assign push_values = {sum_q[SB+1:2], sum_v[SB:1], sum_h[SB:1], a_s_ff};

endmodule

// ===== hdl/gu2x_queue.sv =====
`timescale 1ns / 1ps

module gu2x_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = gu2x_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [DATA_W-1:0]          push_data,
   input  logic                       pop,
   output logic                       head_valid,
   output logic [DATA_W-1:0]          head_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ff, rd_ff;
   logic [CW-1:0]     count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (32'(wr_ff) == DEPTH - 1) ? '0 : wr_ff + PW'(1);
         end
         if (pop) begin
            rd_ff <= (32'(rd_ff) == DEPTH - 1) ? '0 : rd_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ff];
   assign count      = count_ff;

endmodule

// ===== hdl/gu2x_back.sv =====
`timescale 1ns / 1ps

module gu2x_back #(
   parameter int SAMPLE_BITS = gu2x_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  gu2x_pkg::gu2x_ctrl_type          head_ctrl,
   input  logic [4*SAMPLE_BITS-1:0]         head_values,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [gu2x_pkg::ROW_W-1:0]       out_row,
   output logic [gu2x_pkg::COL_W-1:0]       out_col,
   output logic [SAMPLE_BITS-1:0]           value,
   output logic                             last
);

   localparam int SB = SAMPLE_BITS;
   localparam int KW = gu2x_pkg::KIND_W;

   logic                     cur_valid_ff;
   logic [KW-1:0]            kinds_ff, kinds_in;
   gu2x_pkg::gu2x_ctrl_type  ctrl_ff;
   logic [4*SB-1:0]          values_ff;
   logic                     rsp_valid_ff;
   logic [gu2x_pkg::ROW_W-1:0] row_ff, row_in;
   logic [gu2x_pkg::COL_W-1:0] col_ff, col_in;
   logic [SB-1:0]            value_ff, value_in;
   logic                     last_ff;

   logic [KW-1:0]            pick;
   logic                     out_free, emit, done;
   logic [SB-1:0]            v_self, v_horz, v_vert, v_diag;

   always_comb begin
      {v_diag, v_vert, v_horz, v_self} = values_ff;
      pick     = kinds_ff & (~kinds_ff + KW'(1));
      kinds_in = kinds_ff & ~pick;
      done     = (kinds_in == '0);
      out_free = !rsp_valid_ff || rsp_tready;
      emit     = cur_valid_ff && out_free;
      pop      = head_valid && (!cur_valid_ff || (emit && done));
      row_in   = ctrl_ff.row_mid;
      col_in   = ctrl_ff.col_self;
      value_in = v_self;
      case (pick)
         gu2x_pkg::KIND_UP_DIAG: begin
            row_in = ctrl_ff.row_up;  col_in = ctrl_ff.col_left; value_in = v_diag;
         end
         gu2x_pkg::KIND_UP_VERT: begin
            row_in = ctrl_ff.row_up;  col_in = ctrl_ff.col_self; value_in = v_vert;
         end
         gu2x_pkg::KIND_UP_EDGE: begin
            row_in = ctrl_ff.row_up;  col_in = ctrl_ff.col_edge; value_in = v_vert;
         end
         gu2x_pkg::KIND_MID_HORZ: begin
            row_in = ctrl_ff.row_mid; col_in = ctrl_ff.col_left; value_in = v_horz;
         end
         gu2x_pkg::KIND_MID_SELF: begin
            row_in = ctrl_ff.row_mid; col_in = ctrl_ff.col_self; value_in = v_self;
         end
         gu2x_pkg::KIND_MID_EDGE: begin
            row_in = ctrl_ff.row_mid; col_in = ctrl_ff.col_edge; value_in = v_self;
         end
         gu2x_pkg::KIND_BOT_HORZ: begin
            row_in = ctrl_ff.row_bot; col_in = ctrl_ff.col_left; value_in = v_horz;
         end
         gu2x_pkg::KIND_BOT_SELF: begin
            row_in = ctrl_ff.row_bot; col_in = ctrl_ff.col_self; value_in = v_self;
         end
         gu2x_pkg::KIND_BOT_EDGE: begin
            row_in = ctrl_ff.row_bot; col_in = ctrl_ff.col_edge; value_in = v_self;
         end
         default: begin
            row_in = ctrl_ff.row_mid; col_in = ctrl_ff.col_self; value_in = v_self;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cur_valid_ff <= 1'b1;
         end else if (emit && done) begin
            cur_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kinds_ff  <= head_ctrl.kinds;
         ctrl_ff   <= head_ctrl;
         values_ff <= head_values;
      end else if (emit) begin
         kinds_ff <= kinds_in;
      end
      if (emit) begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         value_ff <= value_in;
         last_ff  <= done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign out_row    = row_ff;
   assign out_col    = col_ff;
   assign value      = value_ff;
   assign last       = last_ff;

endmodule
